// ===== hdl/tdpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-of-day palette blender package
// Types, codes, constants and the fixed class table shared by the blender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdpb_pkg;

  localparam int DEF_PALETTE_ENTRIES = 256;

  localparam int IDX_W      = 8;
  localparam int LEVEL_W    = 6;
  localparam int WORD_W     = 3 * LEVEL_W;
  localparam int BANK_W     = 3;
  localparam int MODE_W     = 3;
  localparam int TIME_W     = 11;
  localparam int CLOUD_W    = 7;
  localparam int AMT_W      = 6;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_BANKS  = 5;
  localparam int NUM_CHAN   = 3;

  // Boundaries of the day, in minutes.
  localparam int T_0500 = 5 * 60;
  localparam int T_0600 = 6 * 60;
  localparam int T_0700 = 7 * 60;
  localparam int T_1800 = 18 * 60;
  localparam int T_1900 = 19 * 60;
  localparam int T_2000 = 20 * 60;
  localparam int DUSK_MIN_AMT = 5;
  localparam int CLOUD_MAX    = 100;

  // Truncating division by 60 and by 100 as multiply and shift; exact for
  // dividends up to 63 * 100.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_60  = 15'd17477;
  localparam logic [RECIP_W-1:0] RECIP_100 = 15'd10486;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [BANK_W-1:0] BANK_BASE  = 3'd0;
  localparam logic [BANK_W-1:0] BANK_NIGHT = 3'd1;
  localparam logic [BANK_W-1:0] BANK_DAWN  = 3'd2;
  localparam logic [BANK_W-1:0] BANK_DAY   = 3'd3;
  localparam logic [BANK_W-1:0] BANK_DUSK  = 3'd4;

  localparam logic [1:0] CLASS_PLAIN = 2'd0;
  localparam logic [1:0] CLASS_BLEND = 2'd1;
  localparam logic [1:0] CLASS_FRONT = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_OF_DAY    = 2'd0,
    CFG_CLOUD_AMOUNT   = 2'd1,
    CFG_GREY_LEVEL     = 2'd2,
    CFG_FRONT_VIEW_LIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NIGHT_DAWN = 3'd0,
    MODE_DAWN_DAY   = 3'd1,
    MODE_DAY        = 3'd2,
    MODE_DAY_DUSK   = 3'd3,
    MODE_DUSK_NIGHT = 3'd4,
    MODE_NIGHT      = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                opcode;
    logic [BANK_W-1:0]   bank;
    logic [IDX_W-1:0]    color_index;
    logic [LEVEL_W-1:0]  red_in;
    logic [LEVEL_W-1:0]  green_in;
    logic [LEVEL_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    entry_index;
    logic [LEVEL_W-1:0]  red_out;
    logic [LEVEL_W-1:0]  green_out;
    logic [LEVEL_W-1:0]  blue_out;
    logic [MODE_W-1:0]   blend_mode;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic mix_en;
    logic div_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef struct packed {
    mode_t            mode;
    logic [AMT_W-1:0] amt;
  } mode_amt_t;

  localparam logic [1:0] CLASS_TABLE [0:255] = '{
    2'd0, 2'd2, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0
  };

  // Mode and blend amount for a time of day. Boundary minutes but 19:00 belong
  // to the later period, and any time past midnight counts as night.
  function automatic mode_amt_t pick_mode(input logic [TIME_W-1:0] t);
    mode_amt_t         r;
    logic [TIME_W-1:0] diff;
    r.mode = MODE_NIGHT;
    diff   = '0;
    if (t >= TIME_W'(T_0500) && t < TIME_W'(T_0600)) begin
      r.mode = MODE_NIGHT_DAWN;
      diff   = t - TIME_W'(T_0500);
    end else if (t >= TIME_W'(T_0600) && t < TIME_W'(T_0700)) begin
      r.mode = MODE_DAWN_DAY;
      diff   = t - TIME_W'(T_0600);
    end else if (t >= TIME_W'(T_0700) && t < TIME_W'(T_1800)) begin
      r.mode = MODE_DAY;
    end else if (t >= TIME_W'(T_1800) && t <= TIME_W'(T_1900)) begin
      r.mode = MODE_DAY_DUSK;
      diff   = t - TIME_W'(T_1800);
    end else if (t > TIME_W'(T_1900) && t < TIME_W'(T_2000)) begin
      r.mode = MODE_DUSK_NIGHT;
      diff   = t - TIME_W'(T_1900);
    end
    r.amt = diff[AMT_W-1:0];
    if (r.mode == MODE_DAY_DUSK && r.amt < AMT_W'(DUSK_MIN_AMT)) begin
      r.amt = AMT_W'(DUSK_MIN_AMT);
    end
    return r;
  endfunction

endpackage

// ===== hdl/tdpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Palette blender controller
// Steps a read item through memory read, multiply, divide and output load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdpb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               opcode,
  output logic               in_ready,
  input  tdpb_pkg::status_t  status,
  output tdpb_pkg::cmd_t     cmd
);
  import tdpb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.wr_en  = in_valid && (opcode == OP_WRITE);
        cmd.rd_en  = in_valid && (opcode == OP_READ);
        if (cmd.rd_en) begin
          state_next = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.mix_en = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // Hold here while the previous item still sits in the output register.
        cmd.out_load = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tdpb_datapath.sv =====
// ----------------------------------------------------------------------------
// Palette blender datapath
// Configuration registers, five palette memories, the three-channel blend
// arithmetic and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdpb_datapath #(
  parameter int PALETTE_ENTRIES = tdpb_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [tdpb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tdpb_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  tdpb_pkg::in_item_t                     in_item,
  input  tdpb_pkg::cmd_t                         cmd,
  output tdpb_pkg::status_t                      status,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output tdpb_pkg::out_item_t                    out_item
);
  import tdpb_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [TIME_W-1:0]  time_of_day;
  logic [CLOUD_W-1:0] cloud_amount;
  logic [LEVEL_W-1:0] grey_level;
  logic               front_view_lit;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_of_day    <= '0;
      cloud_amount   <= '0;
      grey_level     <= LEVEL_W'(52);
      front_view_lit <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_OF_DAY:    time_of_day    <= cfg_data[TIME_W-1:0];
        CFG_CLOUD_AMOUNT:   cloud_amount   <= cfg_data[CLOUD_W-1:0];
        CFG_GREY_LEVEL:     grey_level     <= cfg_data[LEVEL_W-1:0];
        CFG_FRONT_VIEW_LIT: front_view_lit <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Palette memories, one per bank, all addressed by the item's index.
  logic              in_range;
  logic [AW-1:0]     addr;
  logic [WORD_W-1:0] wr_word;
  logic [WORD_W-1:0] rd_word [NUM_BANKS];

  assign in_range = {1'b0, in_item.color_index} < (IDX_W + 1)'(PALETTE_ENTRIES);
  assign addr     = in_item.color_index[AW-1:0];
  assign wr_word  = {in_item.red_in, in_item.green_in, in_item.blue_in};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [WORD_W-1:0] mem [PALETTE_ENTRIES];

    always_ff @(posedge clk) begin
      if (cmd.wr_en && in_range && in_item.bank == BANK_W'(b)) begin
        mem[addr] <= wr_word;
      end
      if (cmd.rd_en) begin
        rd_word[b] <= mem[addr];
      end
    end
  end

  // Item context captured when a read is accepted.
  logic [IDX_W-1:0] idx_q;
  mode_t            mode_q;
  logic [AMT_W-1:0] amt_q;
  logic             in_range_q;
  mode_amt_t        mode_amt;

  assign mode_amt = pick_mode(time_of_day);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      idx_q      <= in_item.color_index;
      mode_q     <= mode_amt.mode;
      amt_q      <= mode_amt.amt;
      in_range_q <= in_range;
    end
  end

  // Blend step one: pick the two levels, then |b - a| times the amount.
  logic [LEVEL_W-1:0]         a_q   [NUM_CHAN];
  logic [LEVEL_W+CLOUD_W-1:0] mag_q [NUM_CHAN];
  logic [NUM_CHAN-1:0]        neg_q;
  logic                       den100_q;

  logic [LEVEL_W-1:0]         a_sel   [NUM_CHAN];
  logic [LEVEL_W-1:0]         b_sel   [NUM_CHAN];
  logic [LEVEL_W+CLOUD_W-1:0] mag_sel [NUM_CHAN];
  logic [NUM_CHAN-1:0]        neg_sel;
  logic [CLOUD_W-1:0]         num;
  logic [CLOUD_W-1:0]         cloud_sat;
  logic [1:0]                 cls;
  logic                       blend;

  assign cloud_sat = (cloud_amount > CLOUD_W'(CLOUD_MAX)) ? CLOUD_W'(CLOUD_MAX) : cloud_amount;
  assign cls       = CLASS_TABLE[idx_q];

  always_comb begin
    logic [LEVEL_W-1:0] base_c;
    logic [LEVEL_W-1:0] night_c;
    logic [LEVEL_W-1:0] dawn_c;
    logic [LEVEL_W-1:0] day_c;
    logic [LEVEL_W-1:0] dusk_c;
    logic [LEVEL_W:0]   diff;
    logic [LEVEL_W-1:0] mag_d;
    if (mode_q == MODE_NIGHT_DAWN || mode_q == MODE_DUSK_NIGHT || mode_q == MODE_NIGHT) begin
      blend = (cls == CLASS_BLEND) || (cls == CLASS_FRONT && front_view_lit);
    end else begin
      blend = (cls == CLASS_BLEND);
    end
    num = '0;
    if (blend && in_range_q) begin
      unique case (mode_q)
        MODE_DAY:   num = cloud_sat;
        MODE_NIGHT: num = '0;
        default:    num = CLOUD_W'(amt_q);
      endcase
    end
    for (int c = 0; c < NUM_CHAN; c++) begin
      base_c  = rd_word[BANK_BASE][WORD_W-1-LEVEL_W*c -: LEVEL_W];
      night_c = rd_word[BANK_NIGHT][WORD_W-1-LEVEL_W*c -: LEVEL_W];
      dawn_c  = rd_word[BANK_DAWN][WORD_W-1-LEVEL_W*c -: LEVEL_W];
      day_c   = rd_word[BANK_DAY][WORD_W-1-LEVEL_W*c -: LEVEL_W];
      dusk_c  = rd_word[BANK_DUSK][WORD_W-1-LEVEL_W*c -: LEVEL_W];
      if (!in_range_q) begin
        a_sel[c] = '0;
        b_sel[c] = '0;
      end else if (!blend) begin
        a_sel[c] = base_c;
        b_sel[c] = base_c;
      end else begin
        unique case (mode_q)
          MODE_NIGHT_DAWN: begin a_sel[c] = night_c; b_sel[c] = dawn_c;     end
          MODE_DAWN_DAY:   begin a_sel[c] = dawn_c;  b_sel[c] = day_c;      end
          MODE_DAY:        begin a_sel[c] = day_c;   b_sel[c] = grey_level; end
          MODE_DAY_DUSK:   begin a_sel[c] = day_c;   b_sel[c] = dusk_c;     end
          MODE_DUSK_NIGHT: begin a_sel[c] = dusk_c;  b_sel[c] = night_c;    end
          default:         begin a_sel[c] = night_c; b_sel[c] = night_c;    end
        endcase
      end
      diff       = {1'b0, b_sel[c]} - {1'b0, a_sel[c]};
      neg_sel[c] = diff[LEVEL_W];
      mag_d      = neg_sel[c] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
      mag_sel[c] = (LEVEL_W + CLOUD_W)'(mag_d) * (LEVEL_W + CLOUD_W)'(num);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix_en) begin
      a_q      <= a_sel;
      mag_q    <= mag_sel;
      neg_q    <= neg_sel;
      den100_q <= (mode_q == MODE_DAY);
    end
  end

  // Blend step two: truncating divide by 60 or 100 through a reciprocal.
  localparam int PROD_W = LEVEL_W + CLOUD_W + RECIP_W;

  logic [LEVEL_W-1:0] quo_q [NUM_CHAN];
  logic [LEVEL_W-1:0] quo   [NUM_CHAN];
  logic [RECIP_W-1:0] recip;

  assign recip = den100_q ? RECIP_100 : RECIP_60;

  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod   = PROD_W'(mag_q[c]) * PROD_W'(recip);
      quo[c] = prod[RECIP_SHIFT +: LEVEL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      quo_q <= quo;
    end
  end

  // Final level a +/- quotient; the result always lands inside 0..63.
  logic [LEVEL_W-1:0] level [NUM_CHAN];

  always_comb begin
    logic [LEVEL_W:0] sum;
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum = neg_q[c] ? ({1'b0, a_q[c]} - {1'b0, quo_q[c]})
                     : ({1'b0, a_q[c]} + {1'b0, quo_q[c]});
      level[c] = sum[LEVEL_W-1:0];
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.entry_index <= idx_q;
      out_item.red_out     <= level[0];
      out_item.green_out   <= level[1];
      out_item.blue_out    <= level[2];
      out_item.blend_mode  <= mode_q;
    end
  end

endmodule

// ===== hdl/time_of_day_palette_blender_core.sv =====
// ----------------------------------------------------------------------------
// Time-of-day palette blender
// Five palette banks, blended per entry class and the current time of day.
// ----------------------------------------------------------------------------
// A write item can be taken every cycle while no read is in progress.
// A read item passes memory read at the accepting edge, then level multiply,
// reciprocal divide and an output load that waits for a free output register.
// No new item is taken before that load; the next item is accepted while a
// result waits. Reset clears the controller and output valid, presets the four
// registers; palette contents are not cleared and must be written first.
`timescale 1ns / 1ps

module time_of_day_palette_blender_core #(
  parameter int PALETTE_ENTRIES = tdpb_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tdpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdpb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tdpb_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tdpb_pkg::out_item_t             out_item
);
  import tdpb_pkg::*;

  cmd_t    cmd;
  status_t status;

  tdpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (in_item.opcode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdpb_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/tdpb_checker.sv =====
// ----------------------------------------------------------------------------
// Palette blender port checker
// Watches the item channels of the blender for ordering and mode errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdpb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input tdpb_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input tdpb_pkg::out_item_t out_item
);
  import tdpb_pkg::*;

  logic rd_acc;
  logic wr_acc;

  assign rd_acc = in_valid && in_ready && in_item.opcode == OP_READ;
  assign wr_acc = in_valid && in_ready && in_item.opcode == OP_WRITE;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // A read keeps the block busy for its blend steps.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    rd_acc |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted during a read");

  // Writes never stall the input.
  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    wr_acc |=> in_ready)
    else $error("write item stalled the input");

  // A result cannot appear earlier than the read latency allows.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    rd_acc && (!out_valid || out_ready) |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result appeared too early");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.blend_mode <= MODE_NIGHT)
    else $error("blend mode out of range");

endmodule

bind time_of_day_palette_blender_core tdpb_checker u_tdpb_checker (.*);
